// ===== hw/rtl/sstp_pkg.sv =====
// shared types, constants and fixed-point helpers for the state-space to polynomial block
`timescale 1ns / 1ps
package sstp_pkg;

  localparam int ACC_W = 56;

  localparam logic signed [47:0] Q_ONE = 48'sd65536;
  localparam logic signed [47:0] Q_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Q_MIN = 48'sh8000_0000_0000;
  localparam logic signed [65:0] SAT_HI = 66'sd140737488355327;
  localparam logic signed [65:0] SAT_LO = -66'sd140737488355328;

  typedef enum logic [3:0] {
    ST_LOAD, ST_INIT, ST_PR_RD, ST_CF, ST_RB_RD, ST_CRB, ST_MLO, ST_MHI,
    ST_MRND, ST_ACT, ST_UP_RD, ST_UP_WR, ST_DT, ST_OUT
  } state_t;

  typedef enum logic [2:0] {OP_PR, OP_CF, OP_RB, OP_CRB, OP_DT} op_t;

  typedef enum logic [1:0] {SEC_A, SEC_B, SEC_C, SEC_D} sec_t;

  typedef struct packed {
    logic              ovf;
    logic signed [47:0] val;
  } sat_t;

  function automatic sat_t sat48(input logic signed [65:0] v);
    sat_t s;
    s.ovf = 1'b0;
    s.val = v[47:0];
    if (v > SAT_HI) begin
      s.ovf = 1'b1;
      s.val = Q_MAX;
    end else if (v < SAT_LO) begin
      s.ovf = 1'b1;
      s.val = Q_MIN;
    end
    return s;
  endfunction

  function automatic logic signed [65:0] sx48(input logic signed [47:0] v);
    return {{18{v[47]}}, v};
  endfunction

  function automatic logic signed [65:0] sx56(input logic signed [ACC_W-1:0] v);
    return {{(66-ACC_W){v[ACC_W-1]}}, v};
  endfunction

  // round(65536 / k) in Q16.16
  function automatic logic signed [31:0] recip(input logic [4:0] k);
    logic signed [31:0] r;
    unique case (k)
      5'd1:    r = 32'sd65536;
      5'd2:    r = 32'sd32768;
      5'd3:    r = 32'sd21845;
      5'd4:    r = 32'sd16384;
      5'd5:    r = 32'sd13107;
      5'd6:    r = 32'sd10923;
      5'd7:    r = 32'sd9362;
      5'd8:    r = 32'sd8192;
      5'd9:    r = 32'sd7282;
      5'd10:   r = 32'sd6554;
      5'd11:   r = 32'sd5958;
      5'd12:   r = 32'sd5461;
      5'd13:   r = 32'sd5041;
      5'd14:   r = 32'sd4681;
      5'd15:   r = 32'sd4369;
      5'd16:   r = 32'sd4096;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/state_space_to_transfer_poly_top.sv =====
// characteristic polynomial and numerator of a siso state-space system, one shared multiplier
//
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    in_matrix_value (A row-major, B, C, D)
// out      out  out_valid / out_stall  out_coeff_value, out_is_numerator, out_power,
//                                      out_run_last, out_overflow
// cfg      in   cfg_valid / cfg_ready  cfg_system_order
//
// loading takes one item per cycle while cfg_valid is low; the D item starts the compute
// compute: every multiply goes through the one 33x32 multiplier as a sequence
//   of read, low partial, high partial, round/saturate and accumulate;
//   then 2n+2 transfers out
// no items and no config are taken from the D item until the last result leaves
// reset (synchronous, rst_n low) sets the order to 1 and restarts the load
// out_stall holds the current result; stores need no clearing after reset
`timescale 1ns / 1ps
module state_space_to_transfer_poly_top #(
  parameter int MAX_ORDER = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_matrix_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_coeff_value,
  output logic               out_is_numerator,
  output logic [3:0]         out_power,
  output logic               out_run_last,
  output logic               out_overflow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_system_order
);

  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;
  localparam int CW = $clog2(MAX_ORDER + 1);
  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int ACC_W = sstp_pkg::ACC_W;

  sstp_pkg::state_t state_r, state_nxt;
  sstp_pkg::op_t    op_r, op_nxt;
  sstp_pkg::sec_t   sec_r, sec_nxt;

  logic [3:0]    order_r, order_nxt;
  logic [IW-1:0] li_r, li_nxt, lj_r, lj_nxt;
  logic [IW-1:0] p_r, p_nxt, q_r, q_nxt, r_r, r_nxt;
  logic [CW-1:0] k_r, k_nxt, e_r, e_nxt;
  logic          out_num_r, out_num_nxt;
  logic          ovf_r, ovf_nxt;

  logic signed [ACC_W-1:0] acc_r, acc_nxt, crb_r, crb_nxt, tr_r, tr_nxt;
  logic signed [47:0]      trace_r, trace_nxt, rbs_r, rbs_nxt, coef_r, coef_nxt;
  logic signed [31:0]      d_r;
  logic signed [48:0]      plo_r;
  logic signed [63:0]      phi_r;
  logic signed [47:0]      prod_r;
  logic                    rid_use_r, rid_use_nxt, rid_one_r, rid_one_nxt;

  logic signed [31:0] a_mem [DEPTH];
  logic signed [47:0] r_mem [DEPTH];
  logic signed [47:0] p_mem [DEPTH];
  logic signed [31:0] b_mem [MAX_ORDER];
  logic signed [31:0] c_mem [MAX_ORDER];
  logic signed [47:0] den_r [MAX_ORDER+1];
  logic signed [47:0] num_r [MAX_ORDER+1];

  logic signed [31:0] a_rd_r, b_rd_r, c_rd_r;
  logic signed [47:0] r_rd_r, p_rd_r;

  logic          a_we, b_we, c_we, d_we, r_we, p_we, den_we, num_we;
  logic          a_re, r_re, bc_re, p_re;
  logic [AW-1:0] a_waddr, a_raddr, r_raddr, pq_addr;
  logic [IW-1:0] bc_waddr;
  logic [CW-1:0] den_widx, num_widx;
  logic signed [47:0] den_wdata, num_wdata;

  logic [4:0]    nm1;
  logic          p_last, q_last, r_last, k_last, e_last, first;
  logic [CW-1:0] nk;

  logic signed [47:0] mx;
  logic signed [31:0] my;
  logic signed [32:0] mul_a;
  logic signed [64:0] mul_p;
  logic signed [49:0] lo_rnd;
  logic signed [65:0] t_full;
  sstp_pkg::sat_t     prod_sat;

  logic signed [ACC_W-1:0] sum_a, sum_c, sum_t;
  sstp_pkg::sat_t acc_sat, crb_sat, tr_sat, neg_sat, dt_sat, upd_sat;

  assign nm1    = 5'(order_r) - 5'd1;
  assign p_last = (5'(p_r) == nm1);
  assign q_last = (5'(q_r) == nm1);
  assign r_last = (5'(r_r) == nm1);
  assign k_last = (5'(k_r) == 5'(order_r));
  assign e_last = (5'(e_r) == 5'(order_r));
  assign first  = (k_r == CW'(1));
  assign nk     = CW'(order_r) - k_r;
  assign pq_addr = AW'(p_r * MAX_ORDER + q_r);

  // operand selection for the shared multiplier
  always_comb begin
    unique case (op_r)
      sstp_pkg::OP_PR: begin
        mx = rid_use_r ? (rid_one_r ? sstp_pkg::Q_ONE : 48'sd0) : r_rd_r;
        my = a_rd_r;
      end
      sstp_pkg::OP_CF: begin
        mx = trace_r;
        my = sstp_pkg::recip(5'(k_r));
      end
      sstp_pkg::OP_RB: begin
        mx = rid_use_r ? (rid_one_r ? sstp_pkg::Q_ONE : 48'sd0) : r_rd_r;
        my = b_rd_r;
      end
      sstp_pkg::OP_CRB: begin
        mx = rbs_r;
        my = c_rd_r;
      end
      sstp_pkg::OP_DT: begin
        mx = den_r[e_r];
        my = d_r;
      end
      default: begin
        mx = 48'sd0;
        my = 32'sd0;
      end
    endcase
  end

  // low 16 bits first, then the signed upper 32
  assign mul_a  = (state_r == sstp_pkg::ST_MLO) ? $signed({17'b0, mx[15:0]})
                                                : $signed({mx[47], mx[47:16]});
  assign mul_p  = mul_a * my;
  assign lo_rnd = {plo_r[48], plo_r} + 50'sd32768;
  assign t_full = {{2{phi_r[63]}}, phi_r} + {{32{lo_rnd[49]}}, lo_rnd[49:16]};
  assign prod_sat = sstp_pkg::sat48(t_full);

  assign sum_a   = acc_r + ACC_W'(prod_r);
  assign sum_c   = crb_r + ACC_W'(prod_r);
  assign acc_sat = sstp_pkg::sat48(sstp_pkg::sx56(sum_a));
  assign crb_sat = sstp_pkg::sat48(sstp_pkg::sx56(sum_c));
  assign sum_t   = tr_r + ACC_W'(acc_sat.val);
  assign tr_sat  = sstp_pkg::sat48(sstp_pkg::sx56(sum_t));
  assign neg_sat = sstp_pkg::sat48(66'sd0 - sstp_pkg::sx48(prod_r));
  assign dt_sat  = sstp_pkg::sat48(sstp_pkg::sx48(num_r[e_r]) + sstp_pkg::sx48(prod_r));
  assign upd_sat = sstp_pkg::sat48(sstp_pkg::sx48(p_rd_r) +
                   ((p_r == q_r) ? sstp_pkg::sx48(coef_r) : 66'sd0));

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    sec_nxt     = sec_r;
    order_nxt   = order_r;
    li_nxt      = li_r;
    lj_nxt      = lj_r;
    p_nxt       = p_r;
    q_nxt       = q_r;
    r_nxt       = r_r;
    k_nxt       = k_r;
    e_nxt       = e_r;
    out_num_nxt = out_num_r;
    ovf_nxt     = ovf_r;
    acc_nxt     = acc_r;
    crb_nxt     = crb_r;
    tr_nxt      = tr_r;
    trace_nxt   = trace_r;
    rbs_nxt     = rbs_r;
    coef_nxt    = coef_r;
    rid_use_nxt = rid_use_r;
    rid_one_nxt = rid_one_r;
    a_we = 1'b0; b_we = 1'b0; c_we = 1'b0; d_we = 1'b0;
    r_we = 1'b0; p_we = 1'b0; den_we = 1'b0; num_we = 1'b0;
    a_re = 1'b0; r_re = 1'b0; bc_re = 1'b0; p_re = 1'b0;
    a_waddr   = AW'(li_r * MAX_ORDER + lj_r);
    a_raddr   = AW'(p_r * MAX_ORDER + r_r);
    r_raddr   = AW'(r_r * MAX_ORDER + q_r);
    bc_waddr  = lj_r;
    den_widx  = nk;
    num_widx  = nk;
    den_wdata = neg_sat.val;
    num_wdata = crb_sat.val;
    out_valid = 1'b0;

    unique case (state_r)
      sstp_pkg::ST_LOAD: begin
        if (cfg_valid) begin
          if (cfg_system_order == 4'd0) begin
            order_nxt = 4'd1;
          end else if (5'(cfg_system_order) > 5'(MAX_ORDER)) begin
            order_nxt = 4'(MAX_ORDER);
          end else begin
            order_nxt = cfg_system_order;
          end
          sec_nxt = sstp_pkg::SEC_A;
          li_nxt  = '0;
          lj_nxt  = '0;
        end else if (in_valid) begin
          unique case (sec_r)
            sstp_pkg::SEC_A: begin
              a_we = 1'b1;
              if (5'(lj_r) == nm1) begin
                lj_nxt = '0;
                if (5'(li_r) == nm1) begin
                  li_nxt  = '0;
                  sec_nxt = sstp_pkg::SEC_B;
                end else begin
                  li_nxt = li_r + 1'b1;
                end
              end else begin
                lj_nxt = lj_r + 1'b1;
              end
            end
            sstp_pkg::SEC_B: begin
              b_we = 1'b1;
              if (5'(lj_r) == nm1) begin
                lj_nxt  = '0;
                sec_nxt = sstp_pkg::SEC_C;
              end else begin
                lj_nxt = lj_r + 1'b1;
              end
            end
            sstp_pkg::SEC_C: begin
              c_we = 1'b1;
              if (5'(lj_r) == nm1) begin
                lj_nxt  = '0;
                sec_nxt = sstp_pkg::SEC_D;
              end else begin
                lj_nxt = lj_r + 1'b1;
              end
            end
            sstp_pkg::SEC_D: begin
              d_we      = 1'b1;
              sec_nxt   = sstp_pkg::SEC_A;
              state_nxt = sstp_pkg::ST_INIT;
            end
            default: ;
          endcase
        end
      end

      sstp_pkg::ST_INIT: begin
        den_we    = 1'b1;
        den_widx  = CW'(order_r);
        den_wdata = sstp_pkg::Q_ONE;
        num_we    = 1'b1;
        num_widx  = CW'(order_r);
        num_wdata = 48'sd0;
        k_nxt     = CW'(1);
        p_nxt     = '0;
        q_nxt     = '0;
        r_nxt     = '0;
        acc_nxt   = '0;
        tr_nxt    = '0;
        ovf_nxt   = 1'b0;
        state_nxt = sstp_pkg::ST_PR_RD;
      end

      // product pass: P = A * R, R is the identity on the first step
      sstp_pkg::ST_PR_RD: begin
        a_re        = 1'b1;
        r_re        = 1'b1;
        rid_use_nxt = first;
        rid_one_nxt = (r_r == q_r);
        op_nxt      = sstp_pkg::OP_PR;
        state_nxt   = sstp_pkg::ST_MLO;
      end

      sstp_pkg::ST_CF: begin
        op_nxt    = sstp_pkg::OP_CF;
        state_nxt = sstp_pkg::ST_MLO;
      end

      sstp_pkg::ST_RB_RD: begin
        r_re        = 1'b1;
        bc_re       = 1'b1;
        r_raddr     = pq_addr;
        rid_use_nxt = first;
        rid_one_nxt = (p_r == q_r);
        op_nxt      = sstp_pkg::OP_RB;
        state_nxt   = sstp_pkg::ST_MLO;
      end

      sstp_pkg::ST_CRB: begin
        op_nxt    = sstp_pkg::OP_CRB;
        state_nxt = sstp_pkg::ST_MLO;
      end

      sstp_pkg::ST_DT: begin
        op_nxt    = sstp_pkg::OP_DT;
        state_nxt = sstp_pkg::ST_MLO;
      end

      sstp_pkg::ST_MLO:  state_nxt = sstp_pkg::ST_MHI;
      sstp_pkg::ST_MHI:  state_nxt = sstp_pkg::ST_MRND;
      sstp_pkg::ST_MRND: begin
        ovf_nxt   = ovf_r | prod_sat.ovf;
        state_nxt = sstp_pkg::ST_ACT;
      end

      sstp_pkg::ST_ACT: begin
        unique case (op_r)
          sstp_pkg::OP_PR: begin
            if (r_last) begin
              p_we    = 1'b1;
              ovf_nxt = ovf_r | acc_sat.ovf;
              acc_nxt = '0;
              r_nxt   = '0;
              if (p_r == q_r) tr_nxt = sum_t;
              state_nxt = sstp_pkg::ST_PR_RD;
              if (q_last) begin
                q_nxt = '0;
                if (p_last) begin
                  p_nxt     = '0;
                  trace_nxt = tr_sat.val;
                  ovf_nxt   = ovf_r | acc_sat.ovf | tr_sat.ovf;
                  state_nxt = sstp_pkg::ST_CF;
                end else begin
                  p_nxt = p_r + 1'b1;
                end
              end else begin
                q_nxt = q_r + 1'b1;
              end
            end else begin
              acc_nxt   = sum_a;
              r_nxt     = r_r + 1'b1;
              state_nxt = sstp_pkg::ST_PR_RD;
            end
          end
          sstp_pkg::OP_CF: begin
            den_we    = 1'b1;
            coef_nxt  = neg_sat.val;
            ovf_nxt   = ovf_r | neg_sat.ovf;
            p_nxt     = '0;
            q_nxt     = '0;
            acc_nxt   = '0;
            crb_nxt   = '0;
            state_nxt = sstp_pkg::ST_RB_RD;
          end
          sstp_pkg::OP_RB: begin
            if (q_last) begin
              rbs_nxt   = acc_sat.val;
              ovf_nxt   = ovf_r | acc_sat.ovf;
              acc_nxt   = '0;
              q_nxt     = '0;
              state_nxt = sstp_pkg::ST_CRB;
            end else begin
              acc_nxt   = sum_a;
              q_nxt     = q_r + 1'b1;
              state_nxt = sstp_pkg::ST_RB_RD;
            end
          end
          sstp_pkg::OP_CRB: begin
            if (p_last) begin
              num_we    = 1'b1;
              ovf_nxt   = ovf_r | crb_sat.ovf;
              p_nxt     = '0;
              q_nxt     = '0;
              state_nxt = sstp_pkg::ST_UP_RD;
            end else begin
              crb_nxt   = sum_c;
              p_nxt     = p_r + 1'b1;
              state_nxt = sstp_pkg::ST_RB_RD;
            end
          end
          sstp_pkg::OP_DT: begin
            num_we    = 1'b1;
            num_widx  = e_r;
            num_wdata = dt_sat.val;
            ovf_nxt   = ovf_r | dt_sat.ovf;
            if (e_last) begin
              e_nxt       = '0;
              out_num_nxt = 1'b0;
              state_nxt   = sstp_pkg::ST_OUT;
            end else begin
              e_nxt     = e_r + 1'b1;
              state_nxt = sstp_pkg::ST_DT;
            end
          end
          default: ;
        endcase
      end

      // resolvent update: R = P + coef * I
      sstp_pkg::ST_UP_RD: begin
        p_re      = 1'b1;
        state_nxt = sstp_pkg::ST_UP_WR;
      end

      sstp_pkg::ST_UP_WR: begin
        r_we      = 1'b1;
        ovf_nxt   = ovf_r | upd_sat.ovf;
        state_nxt = sstp_pkg::ST_UP_RD;
        if (q_last) begin
          q_nxt = '0;
          if (p_last) begin
            p_nxt = '0;
            if (k_last) begin
              e_nxt     = '0;
              state_nxt = sstp_pkg::ST_DT;
            end else begin
              k_nxt     = k_r + 1'b1;
              r_nxt     = '0;
              acc_nxt   = '0;
              tr_nxt    = '0;
              state_nxt = sstp_pkg::ST_PR_RD;
            end
          end else begin
            p_nxt = p_r + 1'b1;
          end
        end else begin
          q_nxt = q_r + 1'b1;
        end
      end

      sstp_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (e_last) begin
            e_nxt = '0;
            if (out_num_r) begin
              out_num_nxt = 1'b0;
              state_nxt   = sstp_pkg::ST_LOAD;
            end else begin
              out_num_nxt = 1'b1;
            end
          end else begin
            e_nxt = e_r + 1'b1;
          end
        end
      end

      default: state_nxt = sstp_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sstp_pkg::ST_LOAD;
      sec_r     <= sstp_pkg::SEC_A;
      order_r   <= 4'd1;
      li_r      <= '0;
      lj_r      <= '0;
      e_r       <= '0;
      out_num_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sec_r     <= sec_nxt;
      order_r   <= order_nxt;
      li_r      <= li_nxt;
      lj_r      <= lj_nxt;
      e_r       <= e_nxt;
      out_num_r <= out_num_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    p_r       <= p_nxt;
    q_r       <= q_nxt;
    r_r       <= r_nxt;
    k_r       <= k_nxt;
    acc_r     <= acc_nxt;
    crb_r     <= crb_nxt;
    tr_r      <= tr_nxt;
    trace_r   <= trace_nxt;
    rbs_r     <= rbs_nxt;
    coef_r    <= coef_nxt;
    rid_use_r <= rid_use_nxt;
    rid_one_r <= rid_one_nxt;
    if (d_we) d_r <= in_matrix_value;
    if (state_r == sstp_pkg::ST_MLO) plo_r <= mul_p[48:0];
    if (state_r == sstp_pkg::ST_MHI) phi_r <= mul_p[63:0];
    if (state_r == sstp_pkg::ST_MRND) prod_r <= prod_sat.val;
  end

  always_ff @(posedge clk) begin
    if (a_we) a_mem[a_waddr] <= in_matrix_value;
    if (a_re) a_rd_r <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) r_mem[pq_addr] <= upd_sat.val;
    if (r_re) r_rd_r <= r_mem[r_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) p_mem[pq_addr] <= acc_sat.val;
    if (p_re) p_rd_r <= p_mem[pq_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) b_mem[bc_waddr] <= in_matrix_value;
    if (c_we) c_mem[bc_waddr] <= in_matrix_value;
    if (bc_re) begin
      b_rd_r <= b_mem[q_r];
      c_rd_r <= c_mem[p_r];
    end
  end

  always_ff @(posedge clk) begin
    if (den_we) den_r[den_widx] <= den_wdata;
    if (num_we) num_r[num_widx] <= num_wdata;
  end

  assign in_stall         = (state_r != sstp_pkg::ST_LOAD) || cfg_valid;
  assign cfg_ready        = (state_r == sstp_pkg::ST_LOAD);
  assign out_coeff_value  = out_num_r ? num_r[e_r] : den_r[e_r];
  assign out_is_numerator = out_num_r;
  assign out_power        = 4'(e_r);
  assign out_run_last     = out_num_r && e_last;
  assign out_overflow     = ovf_r;

  // the D item always starts a compute
  a_d_starts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sstp_pkg::ST_LOAD && in_valid && !in_stall && sec_r == sstp_pkg::SEC_D
    |=> state_r == sstp_pkg::ST_INIT)
    else $error("D item did not start the compute");

  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 5'(out_power) <= 5'(order_r))
    else $error("result power beyond the system order");

  // denominator is monic
  a_monic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_numerator && (5'(out_power) == 5'(order_r))
    |-> out_coeff_value == sstp_pkg::Q_ONE)
    else $error("leading denominator coefficient is not one");

  a_last_is_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_last |-> out_is_numerator)
    else $error("run end flagged on a denominator coefficient");

endmodule
